// ===== sv/multi_axis_step_interpolator_defines.svh =====
// assertion helpers for the checker
`ifndef MULTI_AXIS_STEP_INTERPOLATOR_DEFINES_SVH
`define MULTI_AXIS_STEP_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define MSI_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define MSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== sv/msi_pkg.sv =====
package msi_pkg;

  localparam int POS_BITS   = 24;
  localparam int AXES       = 3;
  localparam int FIELD_AXES = 3;
  localparam int SW         = POS_BITS + 1;
  localparam int BW         = $clog2(SW);

  localparam int IN_W     = ((FIELD_AXES * POS_BITS + 7) / 8) * 8;
  localparam int DIR_LO   = FIELD_AXES;
  localparam int POS_LO   = 2 * FIELD_AXES;
  localparam int BUSY_BIT = POS_LO + FIELD_AXES * POS_BITS;
  localparam int OUT_W    = ((BUSY_BIT + 1 + 7) / 8) * 8;

  localparam logic KIND_SEG  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ABS,
    ST_LOAD,
    ST_ACC,
    ST_POS,
    ST_RESP
  } state_t;

endpackage

// ===== sv/multi_axis_step_interpolator.sv =====
// Linear step interpolator for up to three axes.
// Input requests arrive on s_axis: tuser is the kind (segment target or step
// tick), tdata carries target_x, target_y, target_z. One result leaves on m_axis
// per request: tuser = accepted, tlast = seg_done, tdata = pulse, dir, positions,
// busy. A segment is taken only while no segment runs; each tick then moves every
// axis by its exact rounded share of the delta, tracked as a running quotient and
// remainder against the step count.
// All arithmetic is bit serial, one bit per cycle over 25-bit words (24-bit
// words in the position pass), and one request is handled at a time. A segment
// takes a subtract pass and an absolute value / maximum pass, then a load state
// and the response state; a tick takes a remainder pass and a position pass,
// then the response state; an ignored request goes straight to the response
// state. The idle state lies between one request and the next.
// The result sits in an output register: while the receiver stalls it holds, the
// block finishes the current request and waits before writing the next result.
// Synchronous reset clears positions, last targets, direction and the running
// segment; tready returns high on the first cycle after reset.
module multi_axis_step_interpolator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [msi_pkg::IN_W-1:0]  s_axis_tdata,  // target_x, target_y, target_z
  input  logic                      s_axis_tuser,  // kind
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [msi_pkg::OUT_W-1:0] m_axis_tdata,  // pulse_bits, dir_bits, pos_x,
                                                   // pos_y, pos_z, busy_res
  output logic                      m_axis_tuser,  // accepted
  output logic                      m_axis_tlast   // seg_done
);
  import msi_pkg::*;

  state_t state, state_next;
  logic [BW-1:0] bitc;

  logic [POS_BITS-1:0] lt [AXES];
  logic [POS_BITS-1:0] bs [AXES];
  logic [POS_BITS-1:0] ps [AXES];
  logic [SW-1:0]       am [AXES];
  logic [SW-1:0]       rr [AXES];
  logic [SW-1:0]       tt [AXES];
  logic [AXES-1:0]     gb [AXES];
  logic [AXES-1:0]     gbn [AXES];
  logic [SW-1:0]       st, cnt, sel_val;

  logic [AXES-1:0] ng, k0, k1, k2, k3, sp, tp, cy, chg, direction;
  logic [AXES-1:0] s_b, cs_b, t_b, bt_b, b2_b, b3_b, c1_b, rnd_b;
  logic [AXES-1:0] d_b, bo_b, ab_b, op_b, bb_b, cb_b, p_b, cp_b, sel_oh;
  logic [POS_BITS-1:0] tgt [AXES];
  logic kb, nzc, nzs, done, accf, active, first, dec_b;
  logic in_acc, seg_go, tick_go, last_sw, last_w, out_free;
  logic [OUT_W-1:0] out_word;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign seg_go   = (s_axis_tuser == KIND_SEG) & ~active;
  assign tick_go  = (s_axis_tuser == KIND_TICK) & active;
  assign last_sw  = (bitc == BW'(SW - 1));
  assign last_w   = (bitc == BW'(POS_BITS - 1));
  assign out_free = ~m_axis_tvalid | m_axis_tready;
  assign dec_b    = cnt[0] ^ kb;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      tgt[a] = s_axis_tdata[a*POS_BITS +: POS_BITS];
      // segment: delta = target - last target
      d_b[a]  = rr[a][0] ^ tt[a][0] ^ k0[a];
      bo_b[a] = (~rr[a][0] & tt[a][0]) | (~(rr[a][0] ^ tt[a][0]) & k0[a]);
      // serial two's complement negate when the delta is negative
      ab_b[a] = am[a][0] ^ (ng[a] & k0[a]);
      // tick: r + |delta|, then minus steps, and both doubled against steps
      s_b[a]  = rr[a][0] ^ am[a][0] ^ k0[a];
      cs_b[a] = (rr[a][0] & am[a][0]) | (k0[a] & (rr[a][0] ^ am[a][0]));
      t_b[a]  = s_b[a] ^ st[0] ^ k1[a];
      bt_b[a] = (~s_b[a] & st[0]) | (~(s_b[a] ^ st[0]) & k1[a]);
      b2_b[a] = (~sp[a] & st[0]) | (~(sp[a] ^ st[0]) & k2[a]);
      b3_b[a] = (~tp[a] & st[0]) | (~(tp[a] ^ st[0]) & k3[a]);
      c1_b[a] = ~bt_b[a];
      rnd_b[a] = c1_b[a] ? ~b3_b[a] : ~b2_b[a];
      // base moves by one step toward the target on a quotient carry
      op_b[a] = cy[a] & (ng[a] | (bitc == '0));
      bb_b[a] = bs[a][0] ^ op_b[a] ^ k0[a];
      cb_b[a] = (bs[a][0] & op_b[a]) | (k0[a] & (bs[a][0] ^ op_b[a]));
      p_b[a]  = bb_b[a] ^ k1[a];
      cp_b[a] = bb_b[a] & k1[a];
    end
  end

  // pairwise magnitude compare, borrow of axis i minus axis j
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      gbn[i] = '0;
      for (int j = i + 1; j < AXES; j++) begin
        gbn[i][j] = (~ab_b[i] & ab_b[j]) | (~(ab_b[i] ^ ab_b[j]) & gb[i][j]);
      end
    end
  end

  // first axis holding the largest magnitude
  always_comb begin
    logic big, found;
    found   = 1'b0;
    sel_val = '0;
    for (int i = 0; i < AXES; i++) begin
      big = 1'b1;
      for (int j = 0; j < AXES; j++) begin
        if (j < i) big = big & gb[j][i];
        if (j > i) big = big & ~gb[i][j];
      end
      sel_oh[i] = big & ~found;
      found     = found | big;
      if (sel_oh[i]) sel_val = am[i];
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (seg_go) state_next = ST_SUB;
          else if (tick_go) state_next = ST_ACC;
          else state_next = ST_RESP;
        end
      end
      ST_SUB:  if (last_sw) state_next = ST_ABS;
      ST_ABS:  if (last_sw) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_RESP;
      ST_ACC:  if (last_sw) state_next = ST_POS;
      ST_POS:  if (last_w) state_next = ST_RESP;
      ST_RESP: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bitc  <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) bitc <= '0;
      else bitc <= bitc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      first     <= 1'b0;
      direction <= '0;
      accf      <= 1'b0;
      done      <= 1'b0;
      kb        <= 1'b0;
      nzc       <= 1'b0;
      nzs       <= 1'b0;
      {k0, k1, k2, k3, sp, tp, cy, chg, ng} <= '0;
      st  <= '0;
      cnt <= '0;
      for (int a = 0; a < AXES; a++) begin
        lt[a] <= '0;
        ps[a] <= '0;
        bs[a] <= '0;
        am[a] <= '0;
        rr[a] <= '0;
        tt[a] <= '0;
        gb[a] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            accf <= seg_go | tick_go;
            done <= 1'b0;
            kb   <= 1'b1;
            nzc  <= 1'b0;
            nzs  <= 1'b0;
            {k0, k1, k2, k3, sp, tp, chg} <= '0;
            for (int a = 0; a < AXES; a++) begin
              gb[a] <= '0;
              if (seg_go) begin
                rr[a] <= {tgt[a][POS_BITS-1], tgt[a]};
                tt[a] <= {lt[a][POS_BITS-1], lt[a]};
                bs[a] <= lt[a];
                lt[a] <= tgt[a];
              end
            end
          end
        end
        ST_SUB: begin
          for (int a = 0; a < AXES; a++) begin
            am[a] <= {d_b[a], am[a][SW-1:1]};
            rr[a] <= {1'b0, rr[a][SW-1:1]};
            tt[a] <= {1'b0, tt[a][SW-1:1]};
          end
          k0 <= bo_b;
          if (last_sw) begin
            ng <= d_b;
            k0 <= '0;
          end
        end
        ST_ABS: begin
          for (int a = 0; a < AXES; a++) begin
            am[a] <= {ab_b[a], am[a][SW-1:1]};
            gb[a] <= gbn[a];
          end
          for (int a = 0; a < AXES; a++) k0[a] <= k0[a] | am[a][0];
          nzs <= nzs | (|ab_b);
          if (last_sw) k0 <= '0;
        end
        ST_LOAD: begin
          st     <= sel_val;
          cnt    <= sel_val;
          active <= nzs;
          first  <= 1'b1;
        end
        ST_ACC: begin
          st  <= {st[0], st[SW-1:1]};
          cnt <= {dec_b, cnt[SW-1:1]};
          kb  <= ~cnt[0] & kb;
          nzc <= nzc | dec_b;
          for (int a = 0; a < AXES; a++) begin
            am[a] <= {am[a][0], am[a][SW-1:1]};
            rr[a] <= {s_b[a], rr[a][SW-1:1]};
            tt[a] <= {t_b[a], tt[a][SW-1:1]};
            if (last_sw && c1_b[a]) rr[a] <= {t_b[a], tt[a][SW-1:1]};
          end
          k0 <= cs_b;
          k1 <= bt_b;
          k2 <= b2_b;
          k3 <= b3_b;
          sp <= s_b;
          tp <= t_b;
          if (last_sw) begin
            cy   <= c1_b;
            k0   <= '0;
            k1   <= rnd_b & ~ng;
            k2   <= '0;
            k3   <= '0;
            sp   <= '0;
            tp   <= '0;
            done <= ~(nzc | dec_b);
          end
        end
        ST_POS: begin
          for (int a = 0; a < AXES; a++) begin
            bs[a] <= {bb_b[a], bs[a][POS_BITS-1:1]};
            ps[a] <= {p_b[a], ps[a][POS_BITS-1:1]};
            chg[a] <= chg[a] | (p_b[a] ^ ps[a][0]);
          end
          k0 <= cb_b;
          k1 <= cp_b;
          if (last_w) begin
            k0     <= '0;
            k1     <= '0;
            active <= ~done;
            first  <= 1'b0;
            if (first) direction <= ng;
          end
        end
        ST_RESP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_word = '0;
    for (int a = 0; a < AXES; a++) begin
      out_word[AXES-1-a]                    = chg[a];
      out_word[DIR_LO+AXES-1-a]             = direction[a];
      out_word[POS_LO+a*POS_BITS +: POS_BITS] = ps[a];
    end
    out_word[BUSY_BIT] = active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= 1'b0;
      m_axis_tlast  <= 1'b0;
    end else begin
      if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (state == ST_RESP && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= out_word;
        m_axis_tuser  <= accf;
        m_axis_tlast  <= done;
      end
    end
  end

endmodule

// ===== sv/msi_checker.sv =====
`include "multi_axis_step_interpolator_defines.svh"

module msi_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [msi_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tuser,
  input logic                      m_axis_tlast
);
  import msi_pkg::*;

  // a stalled result keeps its payload
  `MSI_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // one request in flight at a time
  `MSI_ASSERT_NEXT(a_one_req, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // the last step of a segment is a performed step and leaves the block idle
  `MSI_ASSERT_IMPL(a_last_acc, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tuser && !m_axis_tdata[BUSY_BIT])

  // an ignored request moves nothing and ends nothing
  `MSI_ASSERT_IMPL(a_ign_quiet, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[FIELD_AXES-1:0] == '0 && !m_axis_tlast)

endmodule

bind multi_axis_step_interpolator msi_checker u_msi_checker (.*);

// ===== sim/tb_multi_axis_step_interpolator.sv =====
`timescale 1ns / 100ps

module tb_multi_axis_step_interpolator;
  import msi_pkg::*;

  localparam int  CYCLE_LIMIT = 3_000_000;
  localparam int  DRAIN_WAIT  = 150;
  localparam int  RANDOM_REQS = 1650;
  localparam longint ROUND_SCALE = 100;
  localparam longint ROUND_HALF  = 50;

  typedef struct packed {
    logic                             acc;
    logic [2:0]                       pulse;
    logic [2:0]                       dir;
    logic [AXES-1:0][POS_BITS-1:0]    pos;
    logic                             done;
    logic                             busy;
  } step_result_t;

  typedef struct packed {
    logic            kind;
    logic [IN_W-1:0] tgt;
  } motion_req_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              s_axis_tuser = KIND_SEG;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tuser;
  logic              m_axis_tlast;

  multi_axis_step_interpolator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  motion_req_t  pending_reqs[$];
  step_result_t step_results_due[$];

  // interpolator shadow state
  logic [AXES-1:0][POS_BITS-1:0] cur_pos;
  longint prev_tgt [AXES];
  longint run_start [AXES];
  longint run_delta [AXES];
  longint run_steps;
  longint step_no;
  logic   running;
  logic [2:0] dir_latch;

  int reqs_offered = 0;
  int reqs_taken = 0;
  int results_seen = 0;
  int results_paced = 0;
  int errors = 0;
  int segs_taken = 0;
  int segs_done = 0;
  int steps_done = 0;
  int ignored = 0;
  int snd_hold = 0;
  int snd_calm = 0;
  int rcv_hold = 0;
  int rcv_calm = 0;
  int cycles = 0;
  longint gen_tgt [AXES];
  motion_req_t  nxt;
  step_result_t got_due;

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 25);
    return $urandom_range(40, 200);
  endfunction

  task automatic queue_segment(input longint x, input longint y, input longint z);
    motion_req_t q;
    q = '0;
    q.kind = KIND_SEG;
    q.tgt[0 +: POS_BITS]          = x[POS_BITS-1:0];
    q.tgt[POS_BITS +: POS_BITS]   = y[POS_BITS-1:0];
    q.tgt[2*POS_BITS +: POS_BITS] = z[POS_BITS-1:0];
    pending_reqs.push_back(q);
  endtask

  task automatic queue_tick();
    motion_req_t q;
    q.kind = KIND_TICK;
    q.tgt  = IN_W'({$urandom, $urandom, $urandom});
    pending_reqs.push_back(q);
  endtask

  // segment that arrives while a run is active, so its targets are dropped
  task automatic queue_stray_segment();
    queue_segment(longint'($urandom), longint'($urandom), longint'($urandom));
  endtask

  task automatic advance_interpolator(input logic kind, input logic [IN_W-1:0] tgt);
    step_result_t r;
    longint t, maxd, mag, m, d, np;
    r = '0;
    if (kind == KIND_SEG) begin
      if (!running) begin
        maxd = 0;
        for (int k = 0; k < AXES; k++) begin
          t = longint'($signed(tgt[k*POS_BITS +: POS_BITS]));
          run_start[k] = prev_tgt[k];
          run_delta[k] = t - prev_tgt[k];
          mag = run_delta[k] < 0 ? -run_delta[k] : run_delta[k];
          if (mag > maxd) maxd = mag;
          prev_tgt[k] = t;
        end
        run_steps = maxd;
        step_no = 0;
        running = (maxd != 0);
        r.acc = 1'b1;
        segs_taken++;
      end else begin
        ignored++;
      end
    end else if (running) begin
      for (int k = 0; k < AXES; k++) begin
        mag = run_delta[k] < 0 ? -run_delta[k] : run_delta[k];
        m = ROUND_SCALE * (step_no + 1) * mag / run_steps;
        d = run_delta[k] < 0 ? -m : m;
        // truncating remainder: negative shares never round up
        if (d % ROUND_SCALE >= ROUND_HALF) d += ROUND_SCALE;
        np = run_start[k] + d / ROUND_SCALE;
        if (np[POS_BITS-1:0] != cur_pos[k]) r.pulse[AXES-1-k] = 1'b1;
        cur_pos[k] = np[POS_BITS-1:0];
      end
      if (step_no == 0) begin
        for (int k = 0; k < AXES; k++) dir_latch[AXES-1-k] = run_delta[k] < 0;
      end
      step_no++;
      if (step_no >= run_steps) begin
        running = 1'b0;
        r.done = 1'b1;
        segs_done++;
      end
      r.acc = 1'b1;
      steps_done++;
    end else begin
      ignored++;
    end
    r.dir  = dir_latch;
    r.pos  = cur_pos;
    r.busy = running;
    step_results_due.push_back(r);
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got, want);
    errors++;
  endtask

  // request side
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      advance_interpolator(s_axis_tuser, s_axis_tdata);
      reqs_taken <= reqs_taken + 1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || reqs_taken == reqs_offered)) begin
      if (snd_hold > 0) begin
        s_axis_tvalid <= 1'b0;
        snd_hold--;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        s_axis_tuser  <= nxt.kind;
        s_axis_tdata  <= nxt.tgt;
        s_axis_tvalid <= 1'b1;
        reqs_offered++;
        snd_hold = pick_gap(snd_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (!rst) begin
      if (results_seen != results_paced) begin
        results_paced = results_seen;
        rcv_hold = pick_gap(rcv_calm);
      end
      if (rcv_hold > 0) begin
        m_axis_tready <= 1'b0;
        rcv_hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (step_results_due.size() == 0) begin
        flag_mismatch("result with nothing pending", m_axis_tdata[BUSY_BIT], 0);
      end else begin
        got_due = step_results_due.pop_front();
        if (m_axis_tuser !== got_due.acc)
          flag_mismatch("accepted", m_axis_tuser, got_due.acc);
        if (m_axis_tdata[2:0] !== got_due.pulse)
          flag_mismatch("pulse_bits", m_axis_tdata[2:0], got_due.pulse);
        if (m_axis_tdata[DIR_LO +: 3] !== got_due.dir)
          flag_mismatch("dir_bits", m_axis_tdata[DIR_LO +: 3], got_due.dir);
        for (int k = 0; k < AXES; k++) begin
          if (m_axis_tdata[POS_LO + k*POS_BITS +: POS_BITS] !== got_due.pos[k])
            flag_mismatch($sformatf("position of axis %0d", k),
                          m_axis_tdata[POS_LO + k*POS_BITS +: POS_BITS], got_due.pos[k]);
        end
        if (m_axis_tlast !== got_due.done)
          flag_mismatch("seg_done", m_axis_tlast, got_due.done);
        if (m_axis_tdata[BUSY_BIT] !== got_due.busy)
          flag_mismatch("busy_res", m_axis_tdata[BUSY_BIT], got_due.busy);
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               step_results_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int eff, mag, steps, pick;
    longint dlt [AXES];

    cur_pos   = '0;
    run_steps = 0;
    step_no   = 0;
    running   = 1'b0;
    dir_latch = '0;
    for (int k = 0; k < AXES; k++) begin
      prev_tgt[k]  = 0;
      run_start[k] = 0;
      run_delta[k] = 0;
    end

    // directed opening
    queue_tick();                              // tick with nothing running
    queue_segment(0, 0, 0);                    // zero-length segment from reset
    queue_segment(3, -2, 0);
    queue_segment(8388607, -8388608, -1);      // dropped, run still active
    repeat (3) queue_tick();
    queue_tick();
    queue_segment(10, -9, 5);                  // mixed directions, fractional shares
    repeat (7) queue_tick();
    queue_segment(10, -9, 5);                  // same target again: nothing to run
    queue_segment(7, -9, 7);
    queue_segment(-8388608, 8388607, 0);       // dropped
    repeat (3) queue_tick();
    gen_tgt[0] = 7;
    gen_tgt[1] = -9;
    gen_tgt[2] = 7;

    // random part: mostly complete segments, some noise around them
    eff = 0;
    while (eff < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_tick();
      end else if (pick < 13) begin
        queue_segment(gen_tgt[0], gen_tgt[1], gen_tgt[2]);
        eff++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 82) mag = $urandom_range(1, 12);
        else if (pick < 97) mag = $urandom_range(13, 60);
        else mag = $urandom_range(61, 300);
        for (int k = 0; k < AXES; k++) begin
          dlt[k] = longint'($urandom_range(0, 2 * mag)) - mag;
          if (gen_tgt[k] + dlt[k] > 200000 || gen_tgt[k] + dlt[k] < -200000)
            dlt[k] = -dlt[k];
        end
        pick = $urandom_range(0, AXES - 1);
        dlt[pick] = gen_tgt[pick] > 0 ? -mag : mag;
        steps = mag;
        for (int k = 0; k < AXES; k++) gen_tgt[k] += dlt[k];
        queue_segment(gen_tgt[0], gen_tgt[1], gen_tgt[2]);
        repeat (steps) begin
          if ($urandom_range(0, 99) < 8) queue_stray_segment();
          queue_tick();
        end
        eff += 1 + steps;
      end
    end

    // closing run over extreme targets, left unfinished
    queue_segment(-8388608, 8388607, gen_tgt[2] + 1);
    repeat (40) begin
      if ($urandom_range(0, 99) < 80) queue_tick();
      else queue_stray_segment();
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_reqs.size() != 0 || reqs_taken != reqs_offered ||
           step_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d requests: %0d segments taken, %0d finished, %0d steps, %0d ignored",
             reqs_taken, segs_taken, segs_done, steps_done, ignored);
    $display("%0d results checked in %0d cycles, %0d mismatches", results_seen, cycles, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/msi_pkg.sv
sv/multi_axis_step_interpolator.sv
sv/msi_checker.sv
sim/tb_multi_axis_step_interpolator.sv
